### design/kdlp_pkg.sv
// ----------------------------------------------------------------------------
// kdlp_pkg
// Shared types and constants for the key debounce / long-press unit.
// ----------------------------------------------------------------------------
`default_nettype none

package kdlp_pkg;

    // key modes
    localparam logic [1:0] MODE_IDLE     = 2'd0;
    localparam logic [1:0] MODE_DEBOUNCE = 2'd1;
    localparam logic [1:0] MODE_PRESSED  = 2'd2;
    localparam logic [1:0] MODE_LONG     = 2'd3;

    // event codes
    localparam logic [1:0] EV_DOWN  = 2'd0;
    localparam logic [1:0] EV_LONG  = 2'd1;
    localparam logic [1:0] EV_CLICK = 2'd2;
    localparam logic [1:0] EV_UP    = 2'd3;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd1;

    localparam int DEB_W    = 8;
    localparam int HOLD_W   = 16;
    localparam int CFG_DATA_W = 16;

    localparam logic [DEB_W-1:0]  DEB_RESET  = 8'd2;
    localparam logic [HOLD_W-1:0] LONG_RESET = 16'd150;

    // output queue
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    typedef struct packed {
        logic [1:0] code;
        logic       last;
    } event_t;

endpackage

`default_nettype wire

### design/key_debounce_long_press_unit.sv
// ----------------------------------------------------------------------------
// key_debounce_long_press_unit
// Debounce and long-press detector for one key, one sampled level per request.
// ----------------------------------------------------------------------------
// Each input request is one tick of the sampled key level. The mode and hold
// counter update in the cycle the tick is accepted, and the one or two
// resulting events go into a four-entry output queue that drives the result
// channel. A tick is taken every cycle while the queue has room for two
// events; a tick that ends a click gives two events, which leave the queue
// one per cycle, so the sustained rate is one tick per cycle as long as the
// result side drains at least as fast as events are made. Configuration
// writes take effect at once and should only be issued while idle.
`default_nettype none

module key_debounce_long_press_unit (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire                              in_valid,
    output logic                             in_ready,
    input  wire                              key_level,
    output logic                             out_valid,
    input  wire                              out_ready,
    output logic [1:0]                       event_code,
    output logic                             last_of_run,
    input  wire                              cfg_wr_en,
    input  wire  [kdlp_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire  [kdlp_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import kdlp_pkg::*;

    logic [DEB_W-1:0]   deb_cnt_reg;
    logic [HOLD_W-1:0]  long_cnt_reg;
    logic [1:0]         mode_reg, mode_next;
    logic [HOLD_W-1:0]  hold_reg, hold_next;
    logic [HOLD_W-1:0]  hold_inc;

    event_t             queue_reg [Q_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [Q_CNT_W-1:0] count_reg, count_next;

    logic               in_fire, out_fire;
    logic [1:0]         n_ev;
    event_t             ev0, ev1;

    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;
    assign in_ready = count_reg <= Q_CNT_W'(Q_DEPTH - 2);
    assign out_valid = count_reg != '0;
    assign event_code  = queue_reg[rd_ptr_reg].code;
    assign last_of_run = queue_reg[rd_ptr_reg].last;

    // saturating tick counter
    assign hold_inc = (hold_reg == '1) ? hold_reg : hold_reg + HOLD_W'(1);

    always_comb
    begin
        mode_next = mode_reg;
        hold_next = hold_reg;
        n_ev      = 2'd0;
        ev0       = '{code: EV_DOWN, last: 1'b1};
        ev1       = '{code: EV_UP, last: 1'b1};
        unique case (mode_reg)
            MODE_IDLE:
            begin
                if (key_level)
                begin
                    mode_next = MODE_DEBOUNCE;
                    hold_next = '0;
                end
            end
            MODE_DEBOUNCE:
            begin
                if (key_level)
                begin
                    hold_next = hold_inc;
                    if (hold_inc >= HOLD_W'(deb_cnt_reg))
                    begin
                        mode_next = MODE_PRESSED;
                        hold_next = '0;
                        n_ev      = 2'd1;
                        ev0       = '{code: EV_DOWN, last: 1'b1};
                    end
                end
                else
                begin
                    mode_next = MODE_IDLE;
                end
            end
            MODE_PRESSED:
            begin
                if (key_level)
                begin
                    hold_next = hold_inc;
                    if (hold_inc >= long_cnt_reg)
                    begin
                        mode_next = MODE_LONG;
                        n_ev      = 2'd1;
                        ev0       = '{code: EV_LONG, last: 1'b1};
                    end
                end
                else
                begin
                    mode_next = MODE_IDLE;
                    n_ev      = 2'd2;
                    ev0       = '{code: EV_CLICK, last: 1'b0};
                    ev1       = '{code: EV_UP, last: 1'b1};
                end
            end
            MODE_LONG:
            begin
                if (!key_level)
                begin
                    mode_next = MODE_IDLE;
                    n_ev      = 2'd1;
                    ev0       = '{code: EV_UP, last: 1'b1};
                end
            end
            default:
            begin
                mode_next = MODE_IDLE;
            end
        endcase
    end

    always_comb
    begin
        count_next = count_reg;
        if (in_fire)
            count_next = count_next + Q_CNT_W'(n_ev);
        if (out_fire)
            count_next = count_next - Q_CNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deb_cnt_reg  <= DEB_RESET;
            long_cnt_reg <= LONG_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                CFG_DEBOUNCE:   deb_cnt_reg  <= cfg_data[DEB_W-1:0];
                CFG_LONG_PRESS: long_cnt_reg <= cfg_data[HOLD_W-1:0];
                default:        ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            hold_reg   <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                mode_reg   <= mode_next;
                hold_reg   <= hold_next;
                wr_ptr_reg <= wr_ptr_reg + Q_PTR_W'(n_ev);
            end
            if (out_fire)
                rd_ptr_reg <= rd_ptr_reg + Q_PTR_W'(1);
            count_reg <= count_next;
        end
    end

    // queue payload, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_fire && n_ev != 2'd0)
            queue_reg[wr_ptr_reg] <= ev0;
        if (in_fire && n_ev == 2'd2)
            queue_reg[wr_ptr_reg + Q_PTR_W'(1)] <= ev1;
    end

endmodule

`default_nettype wire

### design/kdlp_checker.sv
// ----------------------------------------------------------------------------
// kdlp_checker
// Port-level checks for the key debounce / long-press unit.
// ----------------------------------------------------------------------------
`default_nettype none

module kdlp_checker (
    input  wire       clk,
    input  wire       rst_n,
    input  wire       in_valid,
    input  wire       in_ready,
    input  wire       out_valid,
    input  wire       out_ready,
    input  wire [1:0] event_code,
    input  wire       last_of_run
);
    import kdlp_pkg::*;

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(event_code)
            && $stable(last_of_run))
        else $error("stalled result changed");

    // click is always followed at once by up
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && event_code == EV_CLICK |=>
            out_valid && event_code == EV_UP && last_of_run)
        else $error("click not followed by up");

    // only a click opens a two-event run
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !last_of_run |-> event_code == EV_CLICK)
        else $error("non-click event not marked last");

    // click is never the last event of its tick
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && event_code == EV_CLICK |-> !last_of_run)
        else $error("click marked last");

    // with nothing queued, no tick can be refused
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready || !in_valid)
        else $error("input refused while queue empty");

endmodule

bind key_debounce_long_press_unit kdlp_checker u_kdlp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .event_code  (event_code),
    .last_of_run (last_of_run)
);

`default_nettype wire

### test/key_debounce_long_press_unit_tb.sv
// ----------------------------------------------------------------------------
// key_debounce_long_press_unit_tb
// Self-checking bench for the key debounce / long-press unit. Key ticks are
// driven as requests with random idling on both channels, a scoreboard class
// tracks mode and hold count to predict down, long-press, click and up events,
// and every event leaving the block is compared against the oldest prediction.
// ----------------------------------------------------------------------------

module key_debounce_long_press_unit_tb;

    import kdlp_pkg::*;

    localparam int CYCLE_LIMIT   = 600000;
    localparam int SETTLE_CYCLES = 8;
    localparam int SHOWN_MAX     = 10;
    localparam int DEB_MAX       = 255;
    localparam int LONG_MAX      = 65535;

    // indexes with no register behind them
    localparam logic [CFG_IDX_W-1:0] SPARE_IDX_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] SPARE_IDX_B = 2'd3;

    class key_event_board;
        logic [DEB_W-1:0]  deb_limit;
        logic [HOLD_W-1:0] long_limit;
        logic [1:0]        mode;
        logic [HOLD_W-1:0] hold;
        event_t            due_events[$];
        int                errors;
        int                matched;
        int                ticks;
        int                tally[4];

        function new();
            deb_limit  = DEB_RESET;
            long_limit = LONG_RESET;
            mode       = MODE_IDLE;
            hold       = '0;
            errors     = 0;
            matched    = 0;
            ticks      = 0;
            foreach (tally[i])
                tally[i] = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == CFG_DEBOUNCE)
                deb_limit = data[DEB_W-1:0];
            else if (idx == CFG_LONG_PRESS)
                long_limit = data[HOLD_W-1:0];
        endfunction

        function void queue_event(logic [1:0] code, logic last);
            event_t e;
            e.code = code;
            e.last = last;
            due_events.push_back(e);
        endfunction

        function void bump_hold();
            if (hold != '1)
                hold = hold + 1'b1;
        endfunction

        // advance the key state by one accepted tick
        function void note_tick(logic lvl);
            ticks++;
            case (mode)
                MODE_IDLE:
                    if (lvl)
                    begin
                        mode = MODE_DEBOUNCE;
                        hold = '0;
                    end
                MODE_DEBOUNCE:
                    if (lvl)
                    begin
                        bump_hold();
                        if (hold >= {8'd0, deb_limit})
                        begin
                            mode = MODE_PRESSED;
                            hold = '0;
                            queue_event(EV_DOWN, 1'b1);
                        end
                    end
                    else
                    begin
                        mode = MODE_IDLE;
                    end
                MODE_PRESSED:
                    if (lvl)
                    begin
                        bump_hold();
                        if (hold >= long_limit)
                        begin
                            mode = MODE_LONG;
                            queue_event(EV_LONG, 1'b1);
                        end
                    end
                    else
                    begin
                        mode = MODE_IDLE;
                        queue_event(EV_CLICK, 1'b0);
                        queue_event(EV_UP, 1'b1);
                    end
                default:
                    if (!lvl)
                    begin
                        mode = MODE_IDLE;
                        queue_event(EV_UP, 1'b1);
                    end
            endcase
        endfunction

        function void flag(string msg);
            errors++;
            if (errors <= SHOWN_MAX)
                $display("MISMATCH: %s", msg);
        endfunction

        function void check_event(logic [1:0] code, logic last);
            event_t want;
            if (due_events.size() == 0)
            begin
                flag($sformatf("unexpected event code=%0d last=%0d", code, last));
                return;
            end
            want = due_events.pop_front();
            if (code !== want.code)
                flag($sformatf("event %0d: code expected %0d, got %0d",
                               matched, want.code, code));
            if (last !== want.last)
                flag($sformatf("event %0d: last_of_run expected %0d, got %0d",
                               matched, want.last, last));
            tally[want.code]++;
            matched++;
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n       = 1'b0;
    logic                  in_valid    = 1'b0;
    logic                  in_ready;
    logic                  key_level   = 1'b0;
    logic                  out_valid;
    logic                  out_ready   = 1'b0;
    logic [1:0]            event_code;
    logic                  last_of_run;
    logic                  cfg_wr_en   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;

    key_event_board sb = new();

    int cycles       = 0;
    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int rx_hold_req  = 0;
    int ticks_sent   = 0;
    int settings     = 0;

    key_debounce_long_press_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .key_level   (key_level),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .event_code  (event_code),
        .last_of_run (last_of_run),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // results are checked before this edge's request is predicted
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (rst_n)
        begin
            if (out_valid && out_ready)
                sb.check_event(event_code, last_of_run);
            if (in_valid && in_ready)
                sb.note_tick(key_level);
        end
    end

    // result side: random stalls plus an occasional long hold-off
    initial
    begin : result_sink
        int hold_left;
        hold_left = 0;
        forever
        begin
            @(posedge clk);
            if (rx_hold_req > 0)
            begin
                hold_left   = rx_hold_req;
                rx_hold_req = 0;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                out_ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    initial
    begin : watchdog
        wait (cycles >= CYCLE_LIMIT);
        $display("timeout after %0d cycles, %0d events still due",
                 cycles, sb.due_events.size());
        $display("end of test: mismatches");
        $finish;
    end

    task automatic send_tick(input logic lvl);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        key_level <= lvl;
        do
            @(posedge clk);
        while (!in_ready);
        ticks_sent++;
    endtask

    task automatic send_run(input logic lvl, input int n);
        repeat (n)
            send_tick(lvl);
    endtask

    // drop valid, wait for every due event, then let the block go quiet
    task automatic settle();
        in_valid <= 1'b0;
        while (sb.due_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic program_regs(input logic [DEB_W-1:0] deb, input logic [HOLD_W-1:0] lng);
        settle();
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_DEBOUNCE;
        // upper byte is don't-care for the debounce register
        cfg_data  <= {8'($urandom), deb};
        @(posedge clk);
        sb.set_reg(cfg_index, cfg_data);
        cfg_index <= CFG_LONG_PRESS;
        cfg_data  <= lng;
        @(posedge clk);
        sb.set_reg(cfg_index, cfg_data);
        cfg_index <= $urandom_range(1) ? SPARE_IDX_A : SPARE_IDX_B;
        cfg_data  <= 16'($urandom);
        @(posedge clk);
        sb.set_reg(cfg_index, cfg_data);
        cfg_wr_en <= 1'b0;
        settings++;
    endtask

    // mostly press/release runs sized around the thresholds, some raw noise
    task automatic key_traffic(input int n_ticks);
        int stop_at;
        int t_down;
        int t_long;
        int held;
        t_down  = 1 + ((sb.deb_limit == 0) ? 1 : int'(sb.deb_limit));
        t_long  = t_down + ((sb.long_limit == 0) ? 1 : int'(sb.long_limit));
        stop_at = ticks_sent + n_ticks;
        while (ticks_sent < stop_at)
        begin
            if ($urandom_range(99) < 15)
            begin
                repeat ($urandom_range(1, 8))
                    send_tick(1'($urandom_range(1)));
            end
            else
            begin
                case ($urandom_range(3))
                    0:       held = $urandom_range(1, t_down - 1);
                    1:       held = $urandom_range(t_down, t_long - 1);
                    2:       held = t_long + $urandom_range(0, 3);
                    default: held = $urandom_range(t_down - 1, t_long + 1);
                endcase
                send_run(1'b1, held);
                send_run(1'b0, $urandom_range(1, 3));
            end
        end
        // leave the key released before the next register write
        send_run(1'b0, 2);
    endtask

    initial
    begin : stimulus
        repeat (2)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset thresholds: click, then a bounce shorter than debounce
        send_run(1'b1, 3);
        send_run(1'b0, 1);
        send_run(1'b1, 2);
        send_run(1'b0, 1);

        // zero thresholds: second active tick confirms, next one is long press
        program_regs(8'd0, 16'd0);
        send_run(1'b1, 3);
        send_run(1'b0, 1);
        send_run(1'b1, 1);
        send_run(1'b0, 1);

        program_regs(8'd1, 16'd2);
        send_run(1'b1, 3);
        send_run(1'b0, 1);
        send_run(1'b1, 5);
        send_run(1'b0, 2);

        // no idling
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        program_regs(8'd1, 16'd4);
        key_traffic(150);

        // sender idle
        tx_idle_pct = 69;
        program_regs(8'd3, 16'd6);
        key_traffic(150);

        // receiver stalls, with a long hold-off so the queue backs up
        tx_idle_pct  = 0;
        rx_stall_pct = 69;
        program_regs(8'd0, 16'd2);
        rx_hold_req = 300;
        key_traffic(70);
        settle();
        key_traffic(70);

        // both sides idle
        tx_idle_pct  = 30;
        rx_stall_pct = 30;
        program_regs(8'd2, 16'd3);
        key_traffic(130);

        // widest thresholds: press confirmed on the last debounce tick,
        // released long before a long press
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        program_regs(DEB_MAX[DEB_W-1:0], LONG_MAX[HOLD_W-1:0]);
        send_run(1'b1, DEB_MAX + 3);
        send_run(1'b0, 1);

        settle();
        if (sb.due_events.size() != 0)
            sb.flag($sformatf("%0d events never arrived", sb.due_events.size()));

        $display("covered %0d key ticks over %0d register settings, %0d events checked",
                 sb.ticks, settings + 1, sb.matched);
        $display("events: down %0d, long %0d, click %0d, up %0d; failures %0d",
                 sb.tally[EV_DOWN], sb.tally[EV_LONG], sb.tally[EV_CLICK],
                 sb.tally[EV_UP], sb.errors);
        if (sb.errors == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### key_debounce_long_press_unit.f
design/kdlp_pkg.sv
design/key_debounce_long_press_unit.sv
design/kdlp_checker.sv
test/key_debounce_long_press_unit_tb.sv
